// ===== sv/penum_pkg.sv =====
// penum_pkg: shared types and constants for the permutation enumerator.
// Used by permutation_enumerator_unit; depends on nothing else.
package penum_pkg;

  localparam int SYM_W       = 3;   // bits per symbol
  localparam int PACK_SLOTS  = 8;   // symbol slots in the packed output
  localparam int MIN_SYMBOLS = 3;
  localparam int CSUM_W      = 32;

  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item or a register write
    ST_BUILD,  // inside-out rebuild of the partial array, one index a cycle
    ST_LOAD,   // form the base for the current insert position
    ST_EMIT,   // present one permutation, then advance
    ST_BUMP    // ripple the mixed-radix counter, one digit a cycle
  } state_t;

endpackage

// ===== sv/permutation_enumerator_unit.sv =====
// permutation_enumerator_unit: steps through the permutations of m symbols.
// Depends on penum_pkg (types, state encoding, widths).
//
// Flow: a plain item goes from idle to the emit state; a restart item first rebuilds
// the partial array and loads a base. A new item is taken only back in idle: after an
// emit within a base, after a load on a new insert position, or after the digit ripple,
// the rebuild and a load on a counter step. The emit itself waits while out_stall holds.
// Reset (synchronous, active high): count 8, digits, position, rotation and checksum
// cleared, then a rebuild and load in which no item or register write is taken.

module permutation_enumerator_unit #(
  parameter int MAX_SYMBOLS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  element_count,
  // item in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  // result out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] perm_packed,
  output logic [2:0]  rotation_index,
  output logic [31:0] running_checksum,
  output logic        final_perm
);

  // symbol count cap: the packed output holds at most eight symbols
  localparam int CAP   = (MAX_SYMBOLS < penum_pkg::PACK_SLOTS) ? MAX_SYMBOLS
                                                               : penum_pkg::PACK_SLOTS;
  localparam int DEPTH = CAP - 2;   // digits and partial-array entries
  localparam int SW    = penum_pkg::SYM_W;

  penum_pkg::state_t state, state_next;

  // enumeration state
  logic [3:0]                  elem, elem_next;
  penum_pkg::sym_t             digit [DEPTH];
  penum_pkg::sym_t             digit_next [DEPTH];
  penum_pkg::sym_t             part [DEPTH];
  penum_pkg::sym_t             part_next [DEPTH];
  penum_pkg::sym_t             perm [CAP];
  penum_pkg::sym_t             perm_next [CAP];
  logic [2:0]                  pos, pos_next;
  logic [2:0]                  rot, rot_next;
  logic [2:0]                  idx, idx_next;
  logic [penum_pkg::CSUM_W-1:0] csum, csum_next;
  logic                        emit_after, emit_after_next;

  // output register
  logic                        out_valid_next;
  logic [23:0]                 perm_packed_next;
  logic [2:0]                  rotation_index_next;
  logic [31:0]                 running_checksum_next;
  logic                        final_perm_next;

  // working signals
  logic [3:0]      m_eff;
  logic [2:0]      n;
  logic [2:0]      n_less1, n_less2;
  logic            in_fire, out_free, emit_go;
  logic [2:0]      dig_rd, part_addr, part_rd, c_sel;
  logic [2:0]      dig_inc;
  logic            carry;
  logic            rot_last, pos_last, last;
  penum_pkg::sym_t part_ext [CAP];
  penum_pkg::sym_t perm_shift [CAP];
  penum_pkg::sym_t base [CAP];
  penum_pkg::sym_t tail_sym;
  logic [23:0]     packed_now;
  logic [penum_pkg::CSUM_W-1:0] csum_add;

  // ---------------------------------------------------------------------
  // symbol count: saturate the register to 3..CAP
  // ---------------------------------------------------------------------
  always_comb begin
    if (elem < 4'(penum_pkg::MIN_SYMBOLS)) begin
      m_eff = 4'(penum_pkg::MIN_SYMBOLS);
    end else if (elem > 4'(CAP)) begin
      m_eff = 4'(CAP);
    end else begin
      m_eff = elem;
    end
  end
  assign n       = 3'(m_eff - 4'd1);
  assign n_less1 = n - 3'd1;
  assign n_less2 = n - 3'd2;

  // handshakes: one item at a time, a pending result does not block acceptance
  assign cfg_ready = (state == penum_pkg::ST_IDLE);
  assign in_stall  = (state != penum_pkg::ST_IDLE) || cfg_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit_go   = (state == penum_pkg::ST_EMIT) && out_free;

  // ---------------------------------------------------------------------
  // shared read ports: one digit read at idx, one partial-array read
  // ---------------------------------------------------------------------
  always_comb begin
    dig_rd = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (idx == 3'(k)) dig_rd = digit[k];
    end
  end

  assign c_sel   = (dig_rd > idx) ? idx : dig_rd;
  // BUILD reads a[c]; LOAD reads a[pos] (only used when pos < n-1)
  assign part_addr = (state == penum_pkg::ST_BUILD) ? c_sel
                   : ((pos < n_less1) ? pos : 3'd0);

  always_comb begin
    part_rd = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (part_addr == 3'(k)) part_rd = part[k];
    end
  end

  assign dig_inc = dig_rd + 3'd1;
  assign carry   = (dig_inc > idx);

  // ---------------------------------------------------------------------
  // base for the current insert position
  // ---------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < CAP; k++) part_ext[k] = '0;
    for (int k = 0; k < DEPTH; k++) part_ext[k] = part[k];
  end

  always_comb begin
    for (int k = 0; k < CAP; k++) begin
      if (3'(k) < n_less1) begin
        base[k] = (3'(k) == pos) ? n_less1 : part_ext[k];
      end else if (3'(k) == n_less1) begin
        base[k] = (pos < n_less1) ? part_rd : n_less1;
      end else if (3'(k) == n) begin
        base[k] = n;
      end else begin
        base[k] = '0;
      end
    end
  end

  // one-step left rotation within m slots
  always_comb begin
    for (int k = 0; k < CAP; k++) perm_shift[k] = '0;
    for (int k = 0; k < CAP - 1; k++) perm_shift[k] = perm[k + 1];
  end

  // base[n-1] is in slot n-1 while the rotation is zero
  always_comb begin
    tail_sym = '0;
    for (int k = 0; k < CAP; k++) begin
      if (n_less1 == 3'(k)) tail_sym = perm[k];
    end
  end
  assign csum_add = csum + ((rot == 3'd0) ? {{(penum_pkg::CSUM_W-SW){1'b0}}, tail_sym}
                                          : '0);

  always_comb begin
    packed_now = '0;
    for (int k = 0; k < CAP; k++) packed_now[SW*k +: SW] = perm[k];
  end

  // last permutation: inner digits at their maxima, last position, last rotation
  assign rot_last = (rot == n);
  assign pos_last = (pos == n_less1);
  always_comb begin
    last = rot_last && pos_last;
    for (int k = 1; k < DEPTH; k++) begin
      if ((3'(k) < n_less1) && (digit[k] != 3'(k))) last = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      penum_pkg::ST_IDLE: begin
        if (cfg_valid) begin
          state_next = penum_pkg::ST_BUILD;
        end else if (in_fire) begin
          state_next = restart ? penum_pkg::ST_BUILD : penum_pkg::ST_EMIT;
        end
      end
      penum_pkg::ST_BUILD: begin
        if (idx == n_less2) state_next = penum_pkg::ST_LOAD;
      end
      penum_pkg::ST_LOAD: begin
        state_next = emit_after ? penum_pkg::ST_EMIT : penum_pkg::ST_IDLE;
      end
      penum_pkg::ST_EMIT: begin
        if (out_free) begin
          if (!rot_last) begin
            state_next = penum_pkg::ST_IDLE;
          end else if (!pos_last) begin
            state_next = penum_pkg::ST_LOAD;
          end else begin
            state_next = penum_pkg::ST_BUMP;
          end
        end
      end
      penum_pkg::ST_BUMP: begin
        // carry out of digit zero wraps to a full restart; both rebuild
        if (!carry || idx == 3'd0) state_next = penum_pkg::ST_BUILD;
      end
      default: state_next = penum_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath and outputs
  // ---------------------------------------------------------------------
  always_comb begin
    elem_next       = elem;
    digit_next      = digit;
    part_next       = part;
    perm_next       = perm;
    pos_next        = pos;
    rot_next        = rot;
    idx_next        = idx;
    csum_next       = csum;
    emit_after_next = emit_after;

    out_valid_next        = out_valid && out_stall;
    perm_packed_next      = perm_packed;
    rotation_index_next   = rotation_index;
    running_checksum_next = running_checksum;
    final_perm_next       = final_perm;

    unique case (state)
      penum_pkg::ST_IDLE: begin
        if (cfg_valid || (in_fire && restart)) begin
          // register write and restart both start the enumeration over
          if (cfg_valid) elem_next = element_count;
          for (int k = 0; k < DEPTH; k++) digit_next[k] = '0;
          pos_next        = '0;
          rot_next        = '0;
          csum_next       = '0;
          idx_next        = '0;
          emit_after_next = !cfg_valid;
        end
      end
      penum_pkg::ST_BUILD: begin
        // a[i] = a[c]; a[c] = i (second write wins when c == i)
        for (int k = 0; k < DEPTH; k++) begin
          if (3'(k) == c_sel) begin
            part_next[k] = idx;
          end else if (3'(k) == idx) begin
            part_next[k] = part_rd;
          end
        end
        idx_next = idx + 3'd1;
      end
      penum_pkg::ST_LOAD: begin
        perm_next       = base;
        emit_after_next = 1'b0;
      end
      penum_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_next        = 1'b1;
          perm_packed_next      = packed_now;
          rotation_index_next   = rot;
          running_checksum_next = csum_add;
          final_perm_next       = last;
          csum_next             = csum_add;
          if (!rot_last) begin
            rot_next = rot + 3'd1;
            for (int k = 0; k < CAP; k++) begin
              if (3'(k) == n) begin
                perm_next[k] = perm[0];
              end else if (3'(k) < n) begin
                perm_next[k] = perm_shift[k];
              end
            end
          end else if (!pos_last) begin
            rot_next = '0;
            pos_next = pos + 3'd1;
          end else begin
            rot_next = '0;
            pos_next = '0;
            idx_next = n_less2;
          end
        end
      end
      penum_pkg::ST_BUMP: begin
        for (int k = 0; k < DEPTH; k++) begin
          if (3'(k) == idx) digit_next[k] = carry ? 3'd0 : dig_inc;
        end
        if (!carry) begin
          idx_next = '0;
        end else if (idx == 3'd0) begin
          // wrapped: digits already zero, checksum starts over
          idx_next  = '0;
          csum_next = '0;
        end else begin
          idx_next = idx - 3'd1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= penum_pkg::ST_BUILD;
      elem       <= 4'd8;
      for (int k = 0; k < DEPTH; k++) digit[k] <= '0;
      pos        <= '0;
      rot        <= '0;
      idx        <= '0;
      csum       <= '0;
      emit_after <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      elem       <= elem_next;
      digit      <= digit_next;
      pos        <= pos_next;
      rot        <= rot_next;
      idx        <= idx_next;
      csum       <= csum_next;
      emit_after <= emit_after_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    part             <= part_next;
    perm             <= perm_next;
    perm_packed      <= perm_packed_next;
    rotation_index   <= rotation_index_next;
    running_checksum <= running_checksum_next;
    final_perm       <= final_perm_next;
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_item_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != penum_pkg::ST_IDLE))
    else $error("accepted item did not start work");

  a_cfg_rebuilds: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (state == penum_pkg::ST_BUILD))
    else $error("register write did not restart the enumeration");

  a_idle_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == penum_pkg::ST_IDLE) |-> ((rot <= n) && (pos < n)))
    else $error("rotation or insert position out of range when idle");

  a_emit_delivers: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> out_valid)
    else $error("emitted result not presented");

  a_build_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == penum_pkg::ST_BUILD) |-> (idx <= n_less2))
    else $error("rebuild index ran past the partial array");

endmodule

// ===== tb/sv/permutation_enumerator_unit_test.sv =====
// Self-checking testbench for permutation_enumerator_unit: directed and random items
// against a cycle-free predictor of the permutation sequence.
// Depends on penum_pkg and the permutation_enumerator_unit RTL.
module permutation_enumerator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SYM        = 8;
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake of any kind
  localparam int SETTLE_CYCLES  = 4;     // margin after the last result; the write waits for ready

  // One emitted permutation as seen on the output port
  typedef struct {
    logic [23:0] perm;
    logic [2:0]  rot;
    logic [31:0] csum;
    logic        last_perm;
  } perm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  element_count = 4'd8;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] perm_packed;
  logic [2:0]  rotation_index;
  logic [31:0] running_checksum;
  logic        final_perm;

  permutation_enumerator_unit #(.MAX_SYMBOLS(MAX_SYM)) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .element_count    (element_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .perm_packed      (perm_packed),
    .rotation_index   (rotation_index),
    .running_checksum (running_checksum),
    .final_perm       (final_perm)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the count register and the enumeration
  // ---------------------------------------------------------------------------
  logic [3:0]       count_reg;
  penum_pkg::sym_t  digit   [penum_pkg::PACK_SLOTS];  // mixed-radix counter, digit i runs 0..i
  penum_pkg::sym_t  partial [penum_pkg::PACK_SLOTS];  // inside-out array built from the digits
  logic [2:0]       ins_pos;
  logic [2:0]       rot_pos;
  logic [31:0]      csum;

  perm_result_t expected_perms[$];
  perm_result_t want;
  int           err_count   = 0;
  int           idle_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  // Symbols in use: the register clamped to 3..min(MAX_SYMBOLS, 8)
  function automatic int unsigned symbols_in_use();
    int unsigned cap;
    int unsigned m;
    cap = (MAX_SYM < penum_pkg::PACK_SLOTS) ? MAX_SYM : penum_pkg::PACK_SLOTS;
    if (cap < penum_pkg::MIN_SYMBOLS) cap = penum_pkg::MIN_SYMBOLS;
    m = count_reg;
    if (m < penum_pkg::MIN_SYMBOLS) m = penum_pkg::MIN_SYMBOLS;
    if (m > cap) m = cap;
    return m;
  endfunction

  // Inside-out build: a[i] = a[c[i]], then a[c[i]] = i
  function automatic void rebuild_partial(int unsigned n);
    int unsigned i;
    int unsigned c;
    foreach (partial[j]) partial[j] = '0;
    for (i = 0; i + 1 < n; i++) begin
      c = digit[i];
      if (c > i) c = i;
      partial[i] = partial[c];
      partial[c] = penum_pkg::sym_t'(i);
    end
  endfunction

  function automatic void restart_sequence();
    foreach (digit[j]) digit[j] = '0;
    ins_pos = '0;
    rot_pos = '0;
    csum    = '0;
    rebuild_partial(symbols_in_use() - 1);
  endfunction

  // Last digit fastest; returns 1 when the whole counter rolls over
  function automatic bit step_digits(int unsigned n);
    int i;
    i = n - 2;
    while (1) begin
      digit[i] = digit[i] + 1'b1;
      if (digit[i] <= i) return 1'b0;
      digit[i] = '0;
      if (i == 0) return 1'b1;
      i--;
    end
  endfunction

  // Works out the permutation one item produces and moves the sequence on
  function automatic perm_result_t advance_enumeration(bit rs);
    int unsigned      m;
    int unsigned      n;
    int unsigned      k;
    int unsigned      idx;
    int unsigned      pos;
    int unsigned      rot;
    penum_pkg::sym_t  base [penum_pkg::PACK_SLOTS];
    penum_pkg::sym_t  tmp;
    bit               last;
    perm_result_t     r;
    m = symbols_in_use();
    n = m - 1;
    if (rs) restart_sequence();
    if (rot_pos > n) rot_pos = '0;
    if (ins_pos > n - 1) ins_pos = '0;
    pos = ins_pos;
    rot = rot_pos;

    // base = partial, then n-1 and n appended, n-1 swapped into the insert slot
    foreach (base[j]) base[j] = '0;
    for (k = 0; k + 1 < n; k++) base[k] = partial[k];
    base[n-1] = penum_pkg::sym_t'(n - 1);
    base[n]   = penum_pkg::sym_t'(n);
    if (pos < n - 1) begin
      tmp       = base[pos];
      base[pos] = base[n-1];
      base[n-1] = tmp;
    end
    if (rot == 0) csum += 32'(base[n-1]);

    r.perm = '0;
    for (k = 0; k < m; k++) begin
      idx = rot + k;
      if (idx >= m) idx -= m;
      r.perm[3*k +: 3] = base[idx];
    end

    last = 1'b1;
    for (k = 1; k + 1 < n; k++)
      if (digit[k] != k) last = 1'b0;
    if (pos != n - 1 || rot != n) last = 1'b0;
    r.rot       = 3'(rot);
    r.csum      = csum;
    r.last_perm = last;

    rot++;
    if (rot > n) begin
      rot = 0;
      pos++;
      if (pos > n - 1) begin
        pos = 0;
        if (step_digits(n)) begin
          // end of the enumeration: start over, checksum included
          restart_sequence();
          return r;
        end
        rebuild_partial(n);
      end
    end
    ins_pos = 3'(pos);
    rot_pos = 3'(rot);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall, result check at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_perms.size() == 0) begin
        $error("result with nothing expected: perm_packed %h", perm_packed);
        err_count++;
      end else begin
        want = expected_perms.pop_front();
        if (perm_packed !== want.perm) begin
          $error("perm_packed: expected %h, got %h", want.perm, perm_packed);
          err_count++;
        end
        if (rotation_index !== want.rot) begin
          $error("rotation_index: expected %0d, got %0d", want.rot, rotation_index);
          err_count++;
        end
        if (running_checksum !== want.csum) begin
          $error("running_checksum: expected %0d, got %0d", want.csum, running_checksum);
          err_count++;
        end
        if (final_perm !== want.last_perm) begin
          $error("final_perm: expected %0b, got %0b", want.last_perm, final_perm);
          err_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("permutation_enumerator_unit_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // valid stays high after acceptance until the next falling edge, where it
  // is either lowered for a gap or carries the next item: one update per edge
  task automatic send_item(input bit rs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    expected_perms.push_back(advance_enumeration(rs));
  endtask

  // Sender goes quiet and waits for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_perms.size() != 0) @(posedge clk);
  endtask

  // Count register is only written with the block idle; the write restarts it
  task automatic write_count(input logic [3:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    element_count <= value;
    do @(posedge clk); while (!cfg_ready);
    count_reg = value;
    restart_sequence();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_run(input int unsigned count, input bit rs);
    repeat (count) send_item(rs);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Out of reset: eight symbols, first permutations of the sequence
  task automatic test_reset_state();
    send_run(4, 1'b0);
  endtask

  // Count of 0 clamps to three symbols: six permutations, the sixth flagged
  // final, then the sequence and checksum start over on their own
  task automatic test_smallest_count();
    write_count(4'd0);
    send_run(7, 1'b0);
  endtask

  // Other out-of-range counts, both ends
  task automatic test_count_clamp();
    write_count(4'd1);
    send_run(2, 1'b0);
    write_count(4'd2);
    send_run(2, 1'b0);
    write_count(4'd15);
    send_run(2, 1'b0);
    send_item(1'b1);
    write_count(4'd9);
    send_run(2, 1'b0);
  endtask

  // Restart input mid-sequence, then a plain advance after it
  task automatic test_restart_input();
    write_count(4'd4);
    send_run(3, 1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Random counts, mostly small so the sequence wraps often; a rare restart
  task automatic test_random_traffic(input int sp, input int rp, input int unsigned n_items);
    int unsigned sent;
    int unsigned chunk;
    int unsigned k;
    logic [3:0]  value;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) value = 4'($urandom_range(5));
      else value = 4'($urandom);
      write_count(value);
      chunk = $urandom_range(150, 15);
      if (chunk > n_items - sent) chunk = n_items - sent;
      for (k = 0; k < chunk; k++) begin
        // hold back at mid-chunk until the pipeline is empty
        if (k == chunk / 2) drain_results();
        send_item($urandom_range(99) < 4);
      end
      sent += chunk;
    end
  endtask

  initial begin
    count_reg = 4'd8;
    restart_sequence();
    send_idle_pct = 28;
    recv_idle_pct = 56;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_smallest_count();
    test_count_clamp();
    test_restart_input();
    test_random_traffic(28, 56, 410);
    test_random_traffic(56, 28, 410);
    test_random_traffic(0, 0, 410);

    drain_results();
    repeat (SETTLE_CYCLES * 3) @(posedge clk);
    if (err_count == 0) begin
      $display("permutation_enumerator_unit_test: done, clean");
    end else begin
      $display("permutation_enumerator_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/penum_pkg.sv
sv/permutation_enumerator_unit.sv
tb/sv/permutation_enumerator_unit_test.sv
